/* hdl/assert_macros.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mebs_pkg.sv */
// Package: codes, widths and structs of the motor enable bootstrap sequencer.
`default_nettype none
package mebs_pkg;

  // Field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned FB_W      = 4;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned ID_W      = 11;
  localparam int unsigned MODE_W    = 8;
  localparam int unsigned SEQ_W     = 3;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned RETRY_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;

  // Operations
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_POLL      = 3'd1;
  localparam logic [OP_W-1:0] OP_FEEDBACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_LINK_LOST = 3'd3;
  localparam logic [OP_W-1:0] OP_ENABLE    = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd5;
  localparam logic [OP_W-1:0] OP_ZERO      = 3'd6;

  // Actions
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_REG = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ENABLE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ZERO      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET     = 3'd5;

  // Sequencer states
  localparam logic [SEQ_W-1:0] SEQ_IDLE        = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_WRITE_MODE  = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_CLEAR_ERROR = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_ENABLE      = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_WAIT        = 3'd4;
  localparam logic [SEQ_W-1:0] SEQ_ZERO        = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ZERO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IVL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_IVL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ID  = 3'd4;

  // Other constants
  localparam logic [ID_W-1:0]    REG_FRAME_ID   = 11'h7FF;
  localparam logic [FB_W-1:0]    DRIVE_ENABLED  = 4'd1;
  localparam logic [MODE_W-1:0]  MODE_RESET     = 8'd1;
  localparam logic [STEP_W-1:0]  STEP_RESET     = 8'd5;
  localparam logic [RETRY_W-1:0] RETRY_RESET    = 10'd50;
  localparam logic [ID_W-1:0]    MOTOR_ID_RESET = 11'd1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode_code;
    logic               auto_zero_on_boot;
    logic [STEP_W-1:0]  step_interval_ms;
    logic [RETRY_W-1:0] retry_interval_ms;
    logic [ID_W-1:0]    motor_id;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   frame_id;
    logic [MODE_W-1:0] reg_value;
    logic [SEQ_W-1:0]  sequencer_state;
    logic              stopped;
    logic              zero_done;
  } result_t;

endpackage
`default_nettype wire

/* hdl/mebs_in_if.sv */
// Input event channel: valid/ready plus the event fields.
`default_nettype none
interface mebs_in_if;
  logic                       valid;
  logic                       ready;
  logic [mebs_pkg::OP_W-1:0]  operation;
  logic [mebs_pkg::FB_W-1:0]  feedback_state;
  logic                       link_online;

  modport source (output valid, output operation, output feedback_state,
                  output link_online, input ready);
  modport sink   (input valid, input operation, input feedback_state,
                  input link_online, output ready);
endinterface
`default_nettype wire

/* hdl/mebs_out_if.sv */
// Result channel: valid/ready plus the result fields.
`default_nettype none
interface mebs_out_if;
  logic                        valid;
  logic                        ready;
  logic [mebs_pkg::ACT_W-1:0]  action;
  logic [mebs_pkg::ID_W-1:0]   frame_id;
  logic [mebs_pkg::MODE_W-1:0] reg_value;
  logic [mebs_pkg::SEQ_W-1:0]  sequencer_state;
  logic                        stopped;
  logic                        zero_done;

  modport source (output valid, output action, output frame_id, output reg_value,
                  output sequencer_state, output stopped, output zero_done,
                  input ready);
  modport sink   (input valid, input action, input frame_id, input reg_value,
                  input sequencer_state, input stopped, input zero_done,
                  output ready);
endinterface
`default_nettype wire

/* hdl/mebs_cfg.sv */
// Configuration register bank written through the plain write port.
`default_nettype none
module mebs_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mebs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mebs_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  output mebs_pkg::cfg_t                      cfg_o
);
  import mebs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_code         <= MODE_RESET;
      cfg_q.auto_zero_on_boot <= 1'b0;
      cfg_q.step_interval_ms  <= STEP_RESET;
      cfg_q.retry_interval_ms <= RETRY_RESET;
      cfg_q.motor_id          <= MOTOR_ID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE_CODE: cfg_q.mode_code         <= cfg_wdata_i[MODE_W-1:0];
        CFG_AUTO_ZERO: cfg_q.auto_zero_on_boot <= cfg_wdata_i[0];
        CFG_STEP_IVL:  cfg_q.step_interval_ms  <= cfg_wdata_i[STEP_W-1:0];
        CFG_RETRY_IVL: cfg_q.retry_interval_ms <= cfg_wdata_i[RETRY_W-1:0];
        CFG_MOTOR_ID:  cfg_q.motor_id          <= cfg_wdata_i[ID_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* hdl/mebs_seq.sv */
// Sequencer state registers and the single-pass event update logic.
`default_nettype none
`include "assert_macros.svh"
module mebs_seq #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic [mebs_pkg::OP_W-1:0]   operation_i,
  input  wire logic [mebs_pkg::FB_W-1:0]   feedback_state_i,
  input  wire logic                        link_online_i,
  input  wire mebs_pkg::cfg_t              cfg_i,
  output mebs_pkg::result_t                res_o
);
  import mebs_pkg::*;

  localparam int unsigned CMP_W = (ELAPSED_BITS > RETRY_W) ? ELAPSED_BITS : RETRY_W;

  logic [SEQ_W-1:0]        seq_q, seq_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
  logic                    taken_q, taken_d;
  logic                    fresh_q, fresh_d;
  logic                    ever_q, ever_d;
  logic [FB_W-1:0]         drive_q, drive_d;
  logic                    stop_q, stop_d;
  logic                    zeroed_q, zeroed_d;

  logic [ACT_W-1:0] act;
  logic             drive_en;
  logic             step_hold;
  logic             retry_hold;
  logic             go;
  logic [SEQ_W-1:0] seq_eff;
  logic             taken_eff;

  assign drive_en   = ever_q && link_online_i && (drive_q == DRIVE_ENABLED);
  assign step_hold  = CMP_W'(elapsed_q) < CMP_W'(cfg_i.step_interval_ms);
  assign retry_hold = CMP_W'(elapsed_q) < CMP_W'(cfg_i.retry_interval_ms);

  always_comb begin
    seq_d     = seq_q;
    elapsed_d = elapsed_q;
    taken_d   = taken_q;
    fresh_d   = fresh_q;
    ever_d    = ever_q;
    drive_d   = drive_q;
    stop_d    = stop_q;
    zeroed_d  = zeroed_q;
    act       = ACT_NONE;
    go        = 1'b0;
    seq_eff   = seq_q;
    taken_eff = taken_q;

    case (operation_i)
      OP_TICK: begin
        if (elapsed_q != {ELAPSED_BITS{1'b1}}) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end
      OP_POLL: begin
        if (seq_q != SEQ_IDLE) begin
          go = 1'b1;
          if (seq_q == SEQ_WAIT) begin
            if (fresh_q && drive_en) begin
              seq_d   = (cfg_i.auto_zero_on_boot && !zeroed_q) ? SEQ_ZERO : SEQ_IDLE;
              taken_d = 1'b0;
              go      = 1'b0;
            end else if (taken_q && retry_hold) begin
              go = 1'b0;
            end else begin
              // retry timed out or never armed: restart from the mode write
              seq_eff   = SEQ_WRITE_MODE;
              taken_eff = 1'b0;
              seq_d     = SEQ_WRITE_MODE;
              taken_d   = 1'b0;
              fresh_d   = 1'b0;
            end
          end
          if (go && !(taken_eff && step_hold)) begin
            case (seq_eff)
              SEQ_WRITE_MODE: begin
                act   = ACT_WRITE_REG;
                seq_d = SEQ_CLEAR_ERROR;
              end
              SEQ_CLEAR_ERROR: begin
                act   = ACT_CLEAR;
                seq_d = SEQ_ENABLE;
              end
              SEQ_ENABLE: begin
                act   = ACT_ENABLE;
                seq_d = SEQ_WAIT;
              end
              SEQ_ZERO: begin
                act      = ACT_ZERO;
                zeroed_d = 1'b1;
                seq_d    = SEQ_IDLE;
              end
              default: ;
            endcase
            taken_d   = 1'b1;
            elapsed_d = '0;
          end
        end
        // idle, not stopped and drive not up: start over
        if (!stop_q && seq_d == SEQ_IDLE && !drive_en) begin
          seq_d   = SEQ_WRITE_MODE;
          taken_d = 1'b0;
          fresh_d = 1'b0;
        end
      end
      OP_FEEDBACK: begin
        drive_d = feedback_state_i;
        fresh_d = 1'b1;
        ever_d  = 1'b1;
      end
      OP_LINK_LOST: begin
        if (!stop_q && seq_q == SEQ_IDLE) begin
          seq_d   = SEQ_WRITE_MODE;
          taken_d = 1'b0;
          fresh_d = 1'b0;
        end
      end
      OP_ENABLE: begin
        if (stop_q && seq_q == SEQ_IDLE) begin
          seq_d   = SEQ_WRITE_MODE;
          taken_d = 1'b0;
          fresh_d = 1'b0;
        end
        stop_d = 1'b0;
      end
      OP_STOP: begin
        if (!stop_q) begin
          stop_d = 1'b1;
          seq_d  = SEQ_IDLE;
          act    = ACT_RESET;
        end
      end
      OP_ZERO: begin
        act      = ACT_ZERO;
        zeroed_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_WRITE_MODE;
      elapsed_q <= '0;
      taken_q   <= 1'b0;
      fresh_q   <= 1'b0;
      ever_q    <= 1'b0;
      drive_q   <= '0;
      stop_q    <= 1'b0;
      zeroed_q  <= 1'b0;
    end else if (acc_i) begin
      seq_q     <= seq_d;
      elapsed_q <= elapsed_d;
      taken_q   <= taken_d;
      fresh_q   <= fresh_d;
      ever_q    <= ever_d;
      drive_q   <= drive_d;
      stop_q    <= stop_d;
      zeroed_q  <= zeroed_d;
    end
  end

  always_comb begin
    res_o.action          = act;
    res_o.frame_id        = (act == ACT_NONE) ? '0 :
                            (act == ACT_WRITE_REG) ? REG_FRAME_ID : cfg_i.motor_id;
    res_o.reg_value       = (act == ACT_WRITE_REG) ? cfg_i.mode_code : '0;
    res_o.sequencer_state = seq_d;
    res_o.stopped         = stop_d;
    res_o.zero_done       = zeroed_d;
  end

  `ASSERT_NEXT(a_enable_to_wait, acc_i && act == ACT_ENABLE, seq_q == SEQ_WAIT,
               "enable action did not enter wait state")
  `ASSERT_NEXT(a_stop_idles, acc_i && operation_i == OP_STOP && !stop_q,
               stop_q && seq_q == SEQ_IDLE, "stop did not idle the sequencer")
  `ASSERT_NEXT(a_action_clears_timer,
               acc_i && (act == ACT_WRITE_REG || act == ACT_CLEAR || act == ACT_ENABLE),
               elapsed_q == '0 && taken_q, "sequence action did not restart the timer")

endmodule
`default_nettype wire

/* hdl/mebs_out.sv */
// Result register: holds one result until the sink takes it.
`default_nettype none
`include "assert_macros.svh"
module mebs_out (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           acc_i,
  input  wire mebs_pkg::result_t res_i,
  output logic                room_o,
  mebs_out_if.source          out_o
);
  import mebs_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held result leaves this cycle.
  assign room_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (acc_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.action          = res_q.action;
  assign out_o.frame_id        = res_q.frame_id;
  assign out_o.reg_value       = res_q.reg_value;
  assign out_o.sequencer_state = res_q.sequencer_state;
  assign out_o.stopped         = res_q.stopped;
  assign out_o.zero_done       = res_q.zero_done;

  `ASSERT_NEXT(a_accept_fills, acc_i, valid_q, "accepted item produced no result")
  `ASSERT_CLK(a_no_overwrite, !(acc_i && valid_q && !out_o.ready),
              "result register overwritten while held")

endmodule
`default_nettype wire

/* hdl/motor_enable_bootstrap_sequencer_unit.sv */
// Top level of the motor enable bootstrap sequencer.
// Each accepted event (tick, poll, feedback, link lost, enable, stop, zero)
// is applied to the sequencer state and produces exactly one result, which
// appears in the result register on the next cycle. One event can be
// accepted every cycle; the input stalls only while the result register
// holds a result that the sink has not taken. The rate is set by the single
// state-update pass between the sequencer registers and the result register.
// Configuration registers are to be written through cfg_we_i/cfg_index_i/
// cfg_wdata_i only while no event is in flight; the block does not enforce it.
`default_nettype none
module motor_enable_bootstrap_sequencer_unit #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mebs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mebs_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  mebs_in_if.sink                             in_i,
  mebs_out_if.source                          out_o
);
  import mebs_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    room;
  logic    acc;

  assign in_i.ready = room;
  assign acc        = in_i.valid && room;

  mebs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mebs_seq #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .operation_i      (in_i.operation),
    .feedback_state_i (in_i.feedback_state),
    .link_online_i    (in_i.link_online),
    .cfg_i            (cfg),
    .res_o            (res)
  );

  mebs_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .res_i  (res),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
